// ===== design/mistby_pkg.sv =====
package mistby_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOTION_THRESHOLD   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_TIME_MS     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REDUCE_TIME_MS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFF_TIME_MS        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REDUCED_TEMP       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_BRIGHTNESS    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_STANDBY_BRIGHTNESS = 3'd6;

    // Field widths
    localparam int CFG_DATA_W = 32;
    localparam int THR_W      = 18;
    localparam int TIME_W     = 32;
    localparam int TEMP_W     = 9;
    localparam int BRIGHT_W   = 8;
    localparam int AXIS_W     = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;

    // Register reset values
    localparam logic [THR_W-1:0]    RST_MOTION_THRESHOLD   = 18'd820;
    localparam logic [TIME_W-1:0]   RST_SETTLE_TIME_MS     = 32'd5000;
    localparam logic [TIME_W-1:0]   RST_REDUCE_TIME_MS     = 32'd60000;
    localparam logic [TIME_W-1:0]   RST_OFF_TIME_MS        = 32'd120000;
    localparam logic [TEMP_W-1:0]   RST_REDUCED_TEMP       = 9'd160;
    localparam logic [BRIGHT_W-1:0] RST_FULL_BRIGHTNESS    = 8'd255;
    localparam logic [BRIGHT_W-1:0] RST_STANDBY_BRIGHTNESS = 8'd76;

    // Lowest standby target
    localparam logic [TEMP_W-1:0] MIN_REDUCED_TEMP = 9'd50;

    // Item kinds on tuser
    typedef enum logic {
        OP_SAMPLE      = 1'b0,
        OP_MANUAL_STOP = 1'b1
    } t_op;

    // Reported operating mode
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_STANDBY = 2'd1,
        MODE_SLEEP   = 2'd2
    } t_mode;

endpackage

// ===== design/motion_idle_standby_controller.sv =====
// Channel    | Dir | Beat contents
// -----------+-----+--------------------------------------------------------------
// s_axis     | in  | tuser: operation; tdata: timestamp, accel x/y/z, heater,
//            |     |        target temp, display override, manual stop value
// m_axis     | out | tdata: heater on/start/stop, temp write/value, screen,
//            |     |        mode, brightness, manual stopped
// i_cfg      | in  | write enable, register index, write data
//
// One beat is accepted per cycle unless the output stalls; each beat passes
// the input register, then the result register. The state update sits in the
// single stage between them, so beat N+1 sees everything beat N left behind.
// Reset is synchronous: it resets state, empties both registers and loads the
// register defaults. A stalled result register holds while the input register
// still takes one more beat.
module motion_idle_standby_controller #(
    parameter int MAX_TEMPERATURE = 500,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [mistby_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mistby_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // sample stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: timestamp_ms(32) accel_x(16) accel_y(16) accel_z(16)
    //   heater_active(1) target_temp(9) display_override(1) manual_stop_value(1)
    //   zero pad(4)
    input  logic [mistby_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: operation(1)
    input  logic                                s_axis_tuser,
    // result stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: heater_on(1) heater_start(1) heater_stop(1) temp_write(1)
    //   temp_value(9) screen_power(1) mode(2) brightness(8) manual_stopped(1)
    //   zero pad(7)
    output logic [mistby_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import mistby_pkg::*;

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int SUM_W  = SAMPLE_WIDTH + 2;

    // Configuration registers
    logic [THR_W-1:0]    r_motion_threshold;
    logic [TIME_W-1:0]   r_settle_time_ms;
    logic [TIME_W-1:0]   r_reduce_time_ms;
    logic [TIME_W-1:0]   r_off_time_ms;
    logic [TEMP_W-1:0]   r_reduced_temp;
    logic [BRIGHT_W-1:0] r_full_brightness;
    logic [BRIGHT_W-1:0] r_standby_brightness;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_threshold   <= RST_MOTION_THRESHOLD;
            r_settle_time_ms     <= RST_SETTLE_TIME_MS;
            r_reduce_time_ms     <= RST_REDUCE_TIME_MS;
            r_off_time_ms        <= RST_OFF_TIME_MS;
            r_reduced_temp       <= RST_REDUCED_TEMP;
            r_full_brightness    <= RST_FULL_BRIGHTNESS;
            r_standby_brightness <= RST_STANDBY_BRIGHTNESS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_MOTION_THRESHOLD:   r_motion_threshold   <= i_cfg_wdata[THR_W-1:0];
                CFG_SETTLE_TIME_MS:     r_settle_time_ms     <= i_cfg_wdata[TIME_W-1:0];
                CFG_REDUCE_TIME_MS:     r_reduce_time_ms     <= i_cfg_wdata[TIME_W-1:0];
                CFG_OFF_TIME_MS:        r_off_time_ms        <= i_cfg_wdata[TIME_W-1:0];
                CFG_REDUCED_TEMP:       r_reduced_temp       <= i_cfg_wdata[TEMP_W-1:0];
                CFG_FULL_BRIGHTNESS:    r_full_brightness    <= i_cfg_wdata[BRIGHT_W-1:0];
                CFG_STANDBY_BRIGHTNESS: r_standby_brightness <= i_cfg_wdata[BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register advances whenever the result register is free
    logic r_in_vld;
    logic r_out_vld;
    logic w_out_free;
    logic w_advance;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_advance     = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;

    // Input register
    t_op                      r_op;
    logic [TIME_W-1:0]        r_now;
    logic [AXIS_W-1:0]        r_axis [3];
    logic                     r_heater_in;
    logic [TEMP_W-1:0]        r_target;
    logic                     r_override;
    logic                     r_msv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op        <= t_op'(s_axis_tuser);
            r_now       <= s_axis_tdata[31:0];
            r_axis[0]   <= s_axis_tdata[47:32];
            r_axis[1]   <= s_axis_tdata[63:48];
            r_axis[2]   <= s_axis_tdata[79:64];
            r_heater_in <= s_axis_tdata[80];
            r_target    <= s_axis_tdata[89:81];
            r_override  <= s_axis_tdata[90];
            r_msv       <= s_axis_tdata[91];
        end
    end

    // Controller state
    logic [SAMPLE_WIDTH-1:0] r_prev [3];
    logic [TIME_W-1:0]       r_move_time;
    logic                    r_armed;
    logic                    r_standby;
    logic                    r_sleep;
    logic                    r_manual;
    logic [TEMP_W-1:0]       r_saved_temp;
    logic                    r_screen;

    logic [SAMPLE_WIDTH-1:0] n_prev [3];
    logic [TIME_W-1:0]       n_move_time;
    logic                    n_armed;
    logic                    n_standby;
    logic                    n_sleep;
    logic                    n_manual;
    logic [TEMP_W-1:0]       n_saved_temp;
    logic                    n_screen;

    // Per-axis absolute change
    logic signed [DIFF_W-1:0] w_cur  [3];
    logic signed [DIFF_W-1:0] w_old  [3];
    logic signed [DIFF_W-1:0] w_diff [3];
    logic [SAMPLE_WIDTH-1:0]  w_abs  [3];
    logic [SUM_W-1:0]         w_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cur[k]  = DIFF_W'($signed(r_axis[k][SAMPLE_WIDTH-1:0]));
            w_old[k]  = DIFF_W'($signed(r_prev[k]));
            w_diff[k] = w_cur[k] - w_old[k];
            w_abs[k]  = w_diff[k][DIFF_W-1] ? SAMPLE_WIDTH'(-w_diff[k])
                                             : w_diff[k][SAMPLE_WIDTH-1:0];
        end
        w_sum = SUM_W'(w_abs[0]) + SUM_W'(w_abs[1]) + SUM_W'(w_abs[2]);
    end

    // Timing and clamped standby target
    logic [TIME_W-1:0] w_idle;
    logic [TIME_W-1:0] w_red_time;
    logic [TEMP_W-1:0] w_red_temp;
    logic              w_moved;

    assign w_idle     = r_now - r_move_time;
    assign w_red_time = (r_reduce_time_ms < r_off_time_ms) ? r_reduce_time_ms : r_off_time_ms;
    assign w_moved    = THR_W'(w_sum) >= r_motion_threshold;

    always_comb begin
        if (r_reduced_temp < MIN_REDUCED_TEMP) begin
            w_red_temp = MIN_REDUCED_TEMP;
        end else if (r_reduced_temp > TEMP_W'(MAX_TEMPERATURE)) begin
            w_red_temp = TEMP_W'(MAX_TEMPERATURE);
        end else begin
            w_red_temp = r_reduced_temp;
        end
    end

    // Next state and result fields
    logic              w_heater;
    logic              w_start;
    logic              w_stop;
    logic              w_wr;
    logic [TEMP_W-1:0] w_wval;

    always_comb begin
        n_prev       = r_prev;
        n_move_time  = r_move_time;
        n_armed      = r_armed;
        n_standby    = r_standby;
        n_sleep      = r_sleep;
        n_manual     = r_manual;
        n_saved_temp = r_saved_temp;
        n_screen     = r_screen;
        w_heater     = r_heater_in;
        w_start      = 1'b0;
        w_stop       = 1'b0;
        w_wr         = 1'b0;
        w_wval       = '0;

        if (r_op == OP_MANUAL_STOP) begin
            n_manual = r_msv;
        end else begin
            for (int k = 0; k < 3; k++) begin
                n_prev[k] = w_cur[k][SAMPLE_WIDTH-1:0];
            end
            if (w_moved) begin
                // wake on movement and bring the saved target back
                n_move_time = r_now;
                if (r_standby || r_sleep) begin
                    n_screen  = 1'b1;
                    n_standby = 1'b0;
                    n_sleep   = 1'b0;
                    if (!r_heater_in && !r_manual) begin
                        w_heater = 1'b1;
                        w_start  = 1'b1;
                        w_wr     = 1'b1;
                        w_wval   = r_saved_temp;
                    end else if (r_heater_in) begin
                        w_wr   = 1'b1;
                        w_wval = r_saved_temp;
                    end
                end
            end else if (!r_heater_in) begin
                n_armed = 1'b0;
            end else if (!r_armed) begin
                // first still sample with heater running
                n_move_time = r_now;
                n_armed     = 1'b1;
                n_manual    = 1'b0;
            end else if (w_idle >= r_settle_time_ms) begin
                if (w_idle >= r_off_time_ms) begin
                    w_stop    = 1'b1;
                    w_heater  = 1'b0;
                    n_sleep   = 1'b1;
                    n_standby = 1'b0;
                    n_manual  = 1'b0;
                    n_screen  = 1'b0;
                end else if (w_idle >= w_red_time) begin
                    if (!r_standby && !r_sleep) begin
                        n_saved_temp = r_target;
                        n_standby    = 1'b1;
                    end
                    if (r_target != w_red_temp) begin
                        w_wr   = 1'b1;
                        w_wval = w_red_temp;
                    end
                end
            end
        end
    end

    // Mode and brightness from the updated state
    t_mode               w_mode;
    logic [BRIGHT_W-1:0] w_bright;

    always_comb begin
        if (n_sleep) begin
            w_mode = MODE_SLEEP;
        end else if (n_standby) begin
            w_mode = MODE_STANDBY;
        end else begin
            w_mode = MODE_NORMAL;
        end

        if (r_override) begin
            w_bright = r_full_brightness;
        end else if (!w_heater && !n_manual) begin
            w_bright = '0;
        end else if (w_heater && n_standby) begin
            w_bright = r_standby_brightness;
        end else begin
            w_bright = r_full_brightness;
        end
    end

    // Commit state on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_prev[k] <= '0;
            end
            r_move_time  <= '0;
            r_armed      <= 1'b0;
            r_standby    <= 1'b0;
            r_sleep      <= 1'b0;
            r_manual     <= 1'b0;
            r_saved_temp <= '0;
            r_screen     <= 1'b1;
        end else if (w_advance) begin
            r_prev       <= n_prev;
            r_move_time  <= n_move_time;
            r_armed      <= n_armed;
            r_standby    <= n_standby;
            r_sleep      <= n_sleep;
            r_manual     <= n_manual;
            r_saved_temp <= n_saved_temp;
            r_screen     <= n_screen;
        end
    end

    // Result register
    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {7'd0, n_manual, w_bright, w_mode, n_screen, w_wval,
                           w_wr, w_stop, w_start, w_heater};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Standby and sleep are exclusive
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_standby && r_sleep))
        else $error("standby and sleep both set");

    // A heater restart always carries the restored target
    a_start_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[3] && m_axis_tdata[0]))
        else $error("heater start without target write");

    // A stop lands in sleep with the heater and screen off
    a_stop_sleeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |->
        (!m_axis_tdata[0] && !m_axis_tdata[13] && m_axis_tdata[15:14] == MODE_SLEEP))
        else $error("heater stop without sleep");

    // State moves only when a beat is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_advance) && $past(i_rst_n) |->
        $stable(r_move_time) && $stable(r_standby) && $stable(r_sleep))
        else $error("state changed without a processed beat");

endmodule
